### rtl/bvst_pkg.sv
package bvst_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int POS_W    = 4;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_CHANGE = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic                     found;
		logic signed [DATA_W-1:0] read_data;
		logic [4:0]               entry_count;
		status_t                  status;
	} rsp_t;

endpackage

### rtl/bounded_value_set_table_unit.sv
// Channel | Signals                   | Transfer
// req     | req_valid, req_stall, req | req_valid high and req_stall low at clk rise
// rsp     | rsp_valid, rsp_stall, rsp | rsp_valid high and rsp_stall low at clk rise
//
// One request at a time. Query, insert and remove scan the stored entries with one memory
// read per cycle; the scan ends at the first hit or after the last stored entry. A remove
// that hits stops the scan at the hit entry and then closes the gap one entry per cycle on
// the same memory. A read goes through S_READ and S_READ_WAIT, and skips S_READ_WAIT when
// the position is out of range.
// The next request is taken in the cycle after the result is loaded into the output
// register, even if that result is still stalled.
// Reset clears the count and the handshake state; entry contents are left as they are.
module bounded_value_set_table_unit
	import bvst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_READ,
		S_READ_WAIT,
		S_RESP
	} state_t;

	state_t                   state_q;
	cmd_t                     cmd_q;
	logic [DATA_W-1:0]        value_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         rd_ptr_q;
	logic                     cmp_vld_s1;
	logic [IDX_W-1:0]         cmp_idx_s1;
	logic                     res_found_q;
	logic [DATA_W-1:0]        res_data_q;
	status_t                  res_status_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	logic [DATA_W-1:0]        mem [CAPACITY];
	logic [DATA_W-1:0]        mem_rdata_q;
	logic [IDX_W-1:0]         mem_raddr;
	logic                     mem_we;
	logic [IDX_W-1:0]         mem_waddr;
	logic [DATA_W-1:0]        mem_wdata;

	logic                     match;
	logic                     scan_end;
	logic                     full;
	logic                     read_ok;
	logic                     rsp_free;

	assign match    = cmp_vld_s1 && (mem_rdata_q == value_q);
	assign scan_end = (rd_ptr_q == count_q);
	assign full     = (count_q >= CNT_W'(CAPACITY));
	assign read_ok  = (32'(pos_q) < 32'(count_q));
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		mem_raddr = (state_q == S_READ) ? IDX_W'(pos_q) : rd_ptr_q[IDX_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = value_q;
		unique case (state_q)
			S_SEARCH: begin
				// append on a miss
				if (!match && scan_end && cmd_q == CMD_INSERT && !full)
					mem_we = 1'b1;
			end
			S_SHIFT: begin
				// move entry down one place
				if (cmp_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = cmp_idx_s1 - IDX_W'(1);
					mem_wdata = mem_rdata_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rsp_valid_q  <= 1'b0;
			cmp_vld_s1   <= 1'b0;
			rd_ptr_q     <= '0;
			cmd_q        <= CMD_INSERT;
			res_status_q <= ST_OK;
		end else begin
			// load a new result or drop the one just transferred
			if (state_q == S_RESP && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q        <= req.cmd;
						value_q      <= req.value;
						pos_q        <= req.position;
						rd_ptr_q     <= '0;
						cmp_vld_s1   <= 1'b0;
						res_found_q  <= 1'b0;
						res_data_q   <= '0;
						res_status_q <= ST_OK;
						state_q      <= (req.cmd == CMD_READ) ? S_READ : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (match) begin
						cmp_vld_s1  <= 1'b0;
						res_found_q <= 1'b1;
						unique case (cmd_q)
							CMD_INSERT: begin
								res_status_q <= ST_NO_CHANGE;
								state_q      <= S_RESP;
							end
							CMD_REMOVE: state_q <= S_SHIFT;
							default:    state_q <= S_RESP;
						endcase
					end else if (scan_end) begin
						cmp_vld_s1 <= 1'b0;
						unique case (cmd_q)
							CMD_INSERT: begin
								if (full)
									res_status_q <= ST_FULL;
								else
									count_q <= count_q + CNT_W'(1);
							end
							CMD_REMOVE: res_status_q <= ST_NO_CHANGE;
							default: ;
						endcase
						state_q <= S_RESP;
					end else begin
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= rd_ptr_q[IDX_W-1:0];
						rd_ptr_q   <= rd_ptr_q + CNT_W'(1);
					end
				end
				S_SHIFT: begin
					// rd_ptr_q starts one past the hit entry
					if (scan_end) begin
						cmp_vld_s1 <= 1'b0;
						count_q    <= count_q - CNT_W'(1);
						state_q    <= S_RESP;
					end else begin
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= rd_ptr_q[IDX_W-1:0];
						rd_ptr_q   <= rd_ptr_q + CNT_W'(1);
					end
				end
				S_READ: begin
					if (read_ok) begin
						state_q <= S_READ_WAIT;
					end else begin
						res_status_q <= ST_RANGE;
						state_q      <= S_RESP;
					end
				end
				S_READ_WAIT: begin
					res_data_q <= mem_rdata_q;
					state_q    <= S_RESP;
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_q.found       <= res_found_q;
						rsp_q.read_data   <= res_data_q;
						rsp_q.entry_count <= 5'(count_q);
						rsp_q.status      <= res_status_q;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/bvst_checker.sv
module bvst_checker
	import bvst_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.entry_count) <= CAPACITY)
		else $error("entry count above capacity");

	a_data_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.read_data == '0)
		else $error("read data on a failed operation");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.status == ST_OK || rsp.status == ST_NO_CHANGE)
		else $error("found with full or range status");

endmodule

bind bounded_value_set_table_unit bvst_checker u_bvst_checker (.*);
